// ===== rtl/core/jetiu_pkg.sv =====
// Shared types, constants and helpers for the Julia escape-time iterator.
`timescale 1ns / 1ps
package jetiu_pkg;

  localparam int FRAC_BITS_DEF   = 26;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_C_REAL = 2'd0;
  localparam logic [1:0] REG_C_IMAG = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam logic signed [31:0] C_REAL_RST = -32'sd50025644;
  localparam logic signed [31:0] C_IMAG_RST = 32'sd7583690;
  localparam int                 LIMIT_RST  = 2000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic stop;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/jetiu_regs.sv =====
// APB configuration registers: Julia constant and iteration limit.
`timescale 1ns / 1ps
module jetiu_regs #(
  parameter int COUNT_WIDTH = jetiu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jetiu_pkg::ADDR_W-1:0]  paddr,
  input  logic [jetiu_pkg::DATA_W-1:0]  pwdata,
  output logic [jetiu_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output logic signed [31:0]            c_real_o,
  output logic signed [31:0]            c_imag_o,
  output logic [COUNT_WIDTH-1:0]        limit_o
);

  logic signed [31:0]     c_real_q, c_real_d;
  logic signed [31:0]     c_imag_q, c_imag_d;
  logic [COUNT_WIDTH-1:0] limit_q, limit_d;
  logic [1:0]             idx;
  logic                   wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    c_real_d = c_real_q;
    c_imag_d = c_imag_q;
    limit_d  = limit_q;
    if (wr) begin
      case (idx)
        jetiu_pkg::REG_C_REAL: c_real_d = pwdata;
        jetiu_pkg::REG_C_IMAG: c_imag_d = pwdata;
        jetiu_pkg::REG_LIMIT:  limit_d  = COUNT_WIDTH'(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jetiu_pkg::REG_C_REAL: prdata = c_real_q;
      jetiu_pkg::REG_C_IMAG: prdata = c_imag_q;
      jetiu_pkg::REG_LIMIT:  prdata = jetiu_pkg::DATA_W'(limit_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= jetiu_pkg::C_REAL_RST;
      c_imag_q <= jetiu_pkg::C_IMAG_RST;
      limit_q  <= COUNT_WIDTH'(jetiu_pkg::LIMIT_RST);
    end else begin
      c_real_q <= c_real_d;
      c_imag_q <= c_imag_d;
      limit_q  <= limit_d;
    end
  end

  assign c_real_o = c_real_q;
  assign c_imag_o = c_imag_q;
  assign limit_o  = limit_q;

endmodule

// ===== rtl/core/jetiu_dp.sv =====
// Datapath: z registers, product stage, update with saturation, escape test.
`timescale 1ns / 1ps
module jetiu_dp #(
  parameter int FRAC_BITS   = jetiu_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = jetiu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  jetiu_pkg::dp_cmd_t      cmd_i,
  output jetiu_pkg::dp_sts_t      sts_o,
  input  logic signed [31:0]      start_real_i,
  input  logic signed [31:0]      start_imag_i,
  input  logic signed [31:0]      c_real_i,
  input  logic signed [31:0]      c_imag_i,
  input  logic [COUNT_WIDTH-1:0]  limit_i,
  output logic [COUNT_WIDTH-1:0]  iterations_o,
  output logic                    escaped_o,
  output logic                    done_o
);

  localparam logic signed [63:0] BOUND = 64'sd16 <<< FRAC_BITS;

  logic signed [31:0]     zr_q, zr_d, zi_q, zi_d;
  logic signed [63:0]     prr_q, pii_q, pri_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   esc_q, done_q;

  logic signed [63:0] rr, ii, ri, sum_r, sum_i, mag;
  logic signed [63:0] cr_x, ci_x;
  logic               esc;

  assign rr    = prr_q >>> FRAC_BITS;
  assign ii    = pii_q >>> FRAC_BITS;
  assign ri    = pri_q >>> (FRAC_BITS - 1);
  assign cr_x  = {{32{c_real_i[31]}}, c_real_i};
  assign ci_x  = {{32{c_imag_i[31]}}, c_imag_i};
  assign sum_r = rr - ii + cr_x;
  assign sum_i = ri + ci_x;
  assign mag   = rr + ii;
  assign esc   = (mag >= BOUND);

  assign sts_o.first = (cnt_q == '0);
  assign sts_o.stop  = esc | (cnt_q >= limit_i);

  always_comb begin
    zr_d  = zr_q;
    zi_d  = zi_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      zr_d  = start_real_i;
      zi_d  = start_imag_i;
      cnt_d = '0;
    end else if (cmd_i.upd) begin
      zr_d  = jetiu_pkg::sat32(sum_r);
      zi_d  = jetiu_pkg::sat32(sum_i);
      cnt_d = cnt_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q <= zr_d;
    zi_q <= zi_d;
    if (cmd_i.mul) begin
      prr_q <= zr_q * zr_q;
      pii_q <= zi_q * zi_q;
      pri_q <= zr_q * zi_q;
    end
    if (cmd_i.fin) begin
      esc_q <= esc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.fin;
    end
  end

  assign iterations_o = cnt_q;
  assign escaped_o    = esc_q;
  assign done_o       = done_q;

endmodule

// ===== rtl/core/jetiu_ctrl.sv =====
// Controller FSM: alternates multiply and evaluate steps per iteration.
`timescale 1ns / 1ps
module jetiu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  jetiu_pkg::dp_sts_t sts_i,
  output jetiu_pkg::dp_cmd_t cmd_o,
  output logic               busy_o
);

  jetiu_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      jetiu_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = jetiu_pkg::ST_MUL;
        end
      end
      jetiu_pkg::ST_MUL: state_d = jetiu_pkg::ST_EVAL;
      jetiu_pkg::ST_EVAL: begin
        if (!sts_i.first && sts_i.stop) begin
          state_d = jetiu_pkg::ST_IDLE;
        end else begin
          state_d = jetiu_pkg::ST_MUL;
        end
      end
      default: state_d = jetiu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      jetiu_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      jetiu_pkg::ST_MUL: cmd_o.mul = 1'b1;
      jetiu_pkg::ST_EVAL: begin
        // square of the new z doubles as the escape test and next update
        if (!sts_i.first && sts_i.stop) begin
          cmd_o.fin = 1'b1;
        end else begin
          cmd_o.upd = 1'b1;
        end
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jetiu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/julia_escape_time_iterator_unit.sv =====
// Top level of the Julia escape-time iterator.
//
//  channel  | handshake                         | word
//  ---------+-----------------------------------+--------------------------------
//  input    | start & !busy                     | start_real_i, start_imag_i
//  result   | done_o, one cycle                 | iterations_o, escaped_o
//  config   | psel & penable & pwrite (APB)     | c_real, c_imag, iteration_limit
//
// After accept, each iteration of an item is one pass through the 32x32
// multiply stage and one update/escape step. busy drops in the done_o cycle,
// so the next word can be taken at the end of it. Reset puts the FSM in idle
// and the registers at their defaults. The result side cannot stall.
`timescale 1ns / 1ps
module julia_escape_time_iterator_unit #(
  parameter int FRAC_BITS   = jetiu_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = jetiu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            start_real_i,
  input  logic signed [31:0]            start_imag_i,
  output logic                          done_o,
  output logic [COUNT_WIDTH-1:0]        iterations_o,
  output logic                          escaped_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jetiu_pkg::ADDR_W-1:0]  paddr,
  input  logic [jetiu_pkg::DATA_W-1:0]  pwdata,
  output logic [jetiu_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  logic signed [31:0]     c_real, c_imag;
  logic [COUNT_WIDTH-1:0] limit;
  jetiu_pkg::dp_cmd_t     cmd;
  jetiu_pkg::dp_sts_t     sts;

  jetiu_regs #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .c_real_o (c_real),
    .c_imag_o (c_imag),
    .limit_o  (limit)
  );

  jetiu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  jetiu_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_real_i (start_real_i),
    .start_imag_i (start_imag_i),
    .c_real_i     (c_real),
    .c_imag_i     (c_imag),
    .limit_i      (limit),
    .iterations_o (iterations_o),
    .escaped_o    (escaped_o),
    .done_o       (done_o)
  );

endmodule

// ===== rtl/core/jetiu_chk.sv =====
// Port-level checker for the iterator, bound to the top level.
`timescale 1ns / 1ps
module jetiu_chk #(
  parameter int COUNT_WIDTH = jetiu_pkg::COUNT_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [COUNT_WIDTH-1:0] iterations_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result words");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result word");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (iterations_o != '0))
    else $error("result word with zero iterations");

endmodule

bind julia_escape_time_iterator_unit jetiu_chk #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_jetiu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .iterations_o (iterations_o)
);
